// File: rtl/rtg_pkg.sv
// Shared types, constants and the nice-step table of the ruler tick generator.
package rtg_pkg;

  localparam int unsigned IN_W       = 32;
  localparam int unsigned TICK_W     = 35;
  localparam int unsigned STEP_W     = 30;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MPD_W      = 12;
  localparam int unsigned SUB_W      = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PIXEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREF_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBDIV    = 2'd2;

  localparam logic [MPD_W-1:0]      RST_MIN_PIXEL = 12'd8;
  localparam logic [CFG_DATA_W-1:0] RST_PREF_STEP = 32'd25600;
  localparam logic [SUB_W-1:0]      RST_SUBDIV    = 8'd10;

  localparam logic [STEP_W-1:0] STEP_CAP = 30'd1000000000;

  localparam int unsigned NUM_CAND = 28;
  localparam int unsigned CAND_W   = 5;
  localparam logic [CAND_W-1:0] LAST_CAND = CAND_W'(NUM_CAND - 1);

  typedef struct packed {
    logic signed [IN_W-1:0] real_per_pixel;
    logic signed [IN_W-1:0] visible_min;
    logic signed [IN_W-1:0] visible_max;
  } in_item_t;

  typedef struct packed {
    logic signed [TICK_W-1:0] tick_value;
    logic                     is_major;
    logic [STEP_W-1:0]        minor_step;
    logic [STEP_W-1:0]        major_step;
    logic                     is_empty;
    logic                     truncated;
    logic                     is_last;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PIX,
    OP_CEIL,
    OP_SEARCH,
    OP_MAJOR,
    OP_DIV_MIN,
    OP_SAVE_MIN,
    OP_DIV_MAX,
    OP_SAVE_MAX,
    OP_FIRST,
    OP_DIV_FIRST,
    OP_SAVE_FIRST,
    OP_EMIT,
    OP_EMPTY
  } dp_op_t;

  typedef struct packed {
    logic search_done;
    logic range_empty;
    logic div_busy;
    logic emit_last;
  } dp_status_t;

  // Candidate steps 1, 2, 5, 10, 20, 50, ... up to 10^9, in increasing order.
  function automatic logic [STEP_W-1:0] nice_step(input logic [CAND_W-1:0] idx);
    logic [STEP_W-1:0] n;
    unique case (idx)
      5'd0:    n = 30'd1;
      5'd1:    n = 30'd2;
      5'd2:    n = 30'd5;
      5'd3:    n = 30'd10;
      5'd4:    n = 30'd20;
      5'd5:    n = 30'd50;
      5'd6:    n = 30'd100;
      5'd7:    n = 30'd200;
      5'd8:    n = 30'd500;
      5'd9:    n = 30'd1000;
      5'd10:   n = 30'd2000;
      5'd11:   n = 30'd5000;
      5'd12:   n = 30'd10000;
      5'd13:   n = 30'd20000;
      5'd14:   n = 30'd50000;
      5'd15:   n = 30'd100000;
      5'd16:   n = 30'd200000;
      5'd17:   n = 30'd500000;
      5'd18:   n = 30'd1000000;
      5'd19:   n = 30'd2000000;
      5'd20:   n = 30'd5000000;
      5'd21:   n = 30'd10000000;
      5'd22:   n = 30'd20000000;
      5'd23:   n = 30'd50000000;
      5'd24:   n = 30'd100000000;
      5'd25:   n = 30'd200000000;
      5'd26:   n = 30'd500000000;
      default: n = STEP_CAP;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/rtg_div.sv
// Restoring divider, one quotient bit per cycle.
module rtg_div #(
  parameter int unsigned NUM_W = 34,
  parameter int unsigned DEN_W = 38
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             take;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign take    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - CNT_W'(1);
      busy_r <= cnt_r != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], take};
      rem_r <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// File: rtl/rtg_dpath.sv
// Datapath: config registers, step search, range division and tick stepping.
module rtg_dpath #(
  parameter int unsigned MAX_TICKS = 64,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rtg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  rtg_pkg::in_item_t                 in_data,
  input  rtg_pkg::dp_op_t                   op,
  output rtg_pkg::dp_status_t               status,
  output rtg_pkg::out_item_t                out_data
);
  import rtg_pkg::*;

  localparam int unsigned DEN_W  = STEP_W + FRAC_BITS;
  localparam int unsigned NUM_W  = 34;
  localparam int unsigned CNT_W  = $clog2(MAX_TICKS + 1);
  localparam int unsigned PIX_W  = IN_W + MPD_W;
  localparam int unsigned PROD_W = STEP_W + SUB_W;
  localparam logic [CFG_DATA_W:0] FRAC_MASK = (CFG_DATA_W+1)'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [NUM_W:0] MAX_S = (NUM_W+1)'(MAX_TICKS);

  // configuration
  logic [MPD_W-1:0]      mpd_r;
  logic [CFG_DATA_W-1:0] pref_r;
  logic [SUB_W-1:0]      sub_r;

  // request and intermediate values
  logic signed [IN_W-1:0]   rpp_r, vmin_r, vmax_r;
  logic [PIX_W-1:0]         pix_r;
  logic [PIX_W-16:0]        pixc_r;
  logic [CFG_DATA_W:0]      prefc_r;
  logic [CAND_W-1:0]        idx_r;
  logic [STEP_W-1:0]        minor_r, major_r;
  logic signed [NUM_W-1:0]  fq_r, lq_r;
  logic signed [TICK_W-1:0] first_r, v_r;
  logic [STEP_W-1:0]        rm_r;
  logic [CNT_W-1:0]         left_r;
  logic                     trunc_r;
  out_item_t                out_r;

  logic [MPD_W-1:0]         mpd_eff;
  logic [SUB_W-1:0]         sub_eff;
  logic [IN_W-1:0]          mag;
  logic [PIX_W:0]           pix_sum;
  logic [CFG_DATA_W:0]      pref_sum;
  logic [STEP_W-1:0]        cand;
  logic [PROD_W-1:0]        cand_prod;
  logic                     fits;
  logic [CFG_DATA_W-1:0]    pref_int;
  logic [STEP_W-1:0]        major_cap;
  logic signed [NUM_W-1:0]  vmin_x, vmax_x;
  logic [NUM_W-1:0]         vmin_abs, vmax_abs;
  logic [TICK_W-1:0]        first_abs;
  logic                     div_start, div_busy;
  logic [NUM_W-1:0]         div_num, div_quo;
  logic [DEN_W-1:0]         div_den, div_rem;
  logic                     rem_nz;
  logic [NUM_W-1:0]         q_up;
  logic signed [64:0]       first_full;
  logic signed [NUM_W:0]    cnt_full;
  logic [STEP_W:0]          rm_sum;
  logic [STEP_W-1:0]        rm_first;

  assign mpd_eff   = (mpd_r == '0) ? MPD_W'(1) : mpd_r;
  assign sub_eff   = (sub_r == '0) ? SUB_W'(1) : sub_r;
  assign mag       = rpp_r[IN_W-1] ? (~rpp_r + IN_W'(1)) : rpp_r;
  assign pix_sum   = {1'b0, pix_r} + (PIX_W+1)'(16'hFFFF);
  assign pref_sum  = {1'b0, pref_r} + FRAC_MASK;

  // candidate passes when it clears both the pixel spacing and the subdivided major step
  assign cand      = nice_step(idx_r);
  assign cand_prod = PROD_W'(cand) * PROD_W'(sub_eff);
  assign fits      = ({1'b0, cand} >= (STEP_W+1)'(pixc_r)) &&
                     (cand_prod >= PROD_W'(prefc_r));

  assign pref_int  = pref_r >> FRAC_BITS;
  assign major_cap = (pref_int > CFG_DATA_W'(STEP_CAP)) ? STEP_CAP : pref_int[STEP_W-1:0];

  assign vmin_x    = NUM_W'(vmin_r);
  assign vmax_x    = NUM_W'(vmax_r);
  assign vmin_abs  = vmin_x[NUM_W-1] ? NUM_W'(-vmin_x) : NUM_W'(vmin_x);
  assign vmax_abs  = vmax_x[NUM_W-1] ? NUM_W'(-vmax_x) : NUM_W'(vmax_x);
  assign first_abs = first_r[TICK_W-1] ? TICK_W'(-first_r) : TICK_W'(first_r);

  assign div_start = (op == OP_DIV_MIN) || (op == OP_DIV_MAX) || (op == OP_DIV_FIRST);

  always_comb begin
    unique case (op)
      OP_DIV_MAX: begin
        div_num = vmax_abs;
        div_den = DEN_W'(minor_r) << FRAC_BITS;
      end
      OP_DIV_FIRST: begin
        div_num = first_abs[NUM_W-1:0];
        div_den = DEN_W'(major_r);
      end
      default: begin
        div_num = vmin_abs;
        div_den = DEN_W'(minor_r) << FRAC_BITS;
      end
    endcase
  end

  rtg_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign rem_nz     = div_rem != '0;
  assign q_up       = div_quo + NUM_W'(rem_nz);
  assign first_full = fq_r * $signed({1'b0, minor_r});
  assign cnt_full   = (NUM_W+1)'(lq_r) - (NUM_W+1)'(fq_r) + (NUM_W+1)'(1);
  assign rm_sum     = {1'b0, rm_r} + {1'b0, minor_r};
  assign rm_first   = (first_r[TICK_W-1] && rem_nz) ? (major_r - div_rem[STEP_W-1:0])
                                                     : div_rem[STEP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpd_r  <= RST_MIN_PIXEL;
      pref_r <= RST_PREF_STEP;
      sub_r  <= RST_SUBDIV;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_PIXEL: mpd_r  <= cfg_data[MPD_W-1:0];
        CFG_PREF_STEP: pref_r <= cfg_data;
        CFG_SUBDIV:    sub_r  <= cfg_data[SUB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        rpp_r  <= in_data.real_per_pixel;
        vmin_r <= in_data.visible_min;
        vmax_r <= in_data.visible_max;
      end
      OP_PIX:    pix_r <= PIX_W'(mag) * PIX_W'(mpd_eff);
      OP_CEIL: begin
        pixc_r  <= pix_sum[PIX_W:16];
        prefc_r <= pref_sum >> FRAC_BITS;
        idx_r   <= '0;
      end
      OP_SEARCH: begin
        minor_r <= cand;
        idx_r   <= idx_r + CAND_W'(1);
      end
      OP_MAJOR:  major_r <= (major_cap < minor_r) ? minor_r : major_cap;
      OP_SAVE_MIN: fq_r <= vmin_r[IN_W-1] ? NUM_W'(-$signed(q_up)) : $signed(div_quo);
      OP_SAVE_MAX: lq_r <= (vmax_r > 0) ? $signed(q_up) : NUM_W'(-$signed(div_quo));
      OP_FIRST: begin
        first_r <= first_full[TICK_W-1:0];
        trunc_r <= cnt_full > MAX_S;
        left_r  <= (cnt_full > MAX_S) ? CNT_W'(MAX_TICKS) : cnt_full[CNT_W-1:0];
      end
      OP_SAVE_FIRST: begin
        rm_r <= rm_first;
        v_r  <= first_r;
      end
      OP_EMIT: begin
        out_r.tick_value <= v_r;
        out_r.is_major   <= rm_r == '0;
        out_r.minor_step <= minor_r;
        out_r.major_step <= major_r;
        out_r.is_empty   <= 1'b0;
        out_r.truncated  <= trunc_r && (left_r == CNT_W'(1));
        out_r.is_last    <= left_r == CNT_W'(1);
        v_r    <= v_r + TICK_W'(minor_r);
        rm_r   <= (rm_sum >= {1'b0, major_r}) ? STEP_W'(rm_sum - {1'b0, major_r})
                                              : rm_sum[STEP_W-1:0];
        left_r <= left_r - CNT_W'(1);
      end
      OP_EMPTY: begin
        out_r.tick_value <= '0;
        out_r.is_major   <= 1'b0;
        out_r.minor_step <= minor_r;
        out_r.major_step <= major_r;
        out_r.is_empty   <= 1'b1;
        out_r.truncated  <= 1'b0;
        out_r.is_last    <= 1'b1;
      end
      default: ;
    endcase
  end

  assign status.search_done = fits || (idx_r == LAST_CAND);
  assign status.range_empty = vmin_r >= vmax_r;
  assign status.div_busy    = div_busy;
  assign status.emit_last   = left_r == CNT_W'(1);
  assign out_data           = out_r;

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  a_emit_has_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_EMIT) |-> (left_r != '0)) else $error("tick emitted with none left");

  a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_EMIT) |-> (rm_r < major_r)) else $error("major residue out of range");

  a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
    ((op == OP_EMIT) || (op == OP_EMPTY)) |-> ((minor_r != '0) && (minor_r <= major_r)))
    else $error("minor step zero or above major step");

endmodule

// File: rtl/rtg_ctrl.sv
// Controller: sequences one view request through the datapath and drives the handshakes.
module rtg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rtg_pkg::dp_status_t status,
  output rtg_pkg::dp_op_t     op
);
  import rtg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PIX,
    S_CEIL,
    S_SEARCH,
    S_MAJOR,
    S_DMIN,
    S_WMIN,
    S_DMAX,
    S_WMAX,
    S_FIRST,
    S_DFIRST,
    S_WFIRST,
    S_EMIT,
    S_EMPTY
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    op            = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = S_PIX;
        end
      end
      S_PIX: begin
        op        = OP_PIX;
        state_nxt = S_CEIL;
      end
      S_CEIL: begin
        op        = OP_CEIL;
        state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        op = OP_SEARCH;
        if (status.search_done) state_nxt = S_MAJOR;
      end
      S_MAJOR: begin
        op        = OP_MAJOR;
        state_nxt = status.range_empty ? S_EMPTY : S_DMIN;
      end
      S_DMIN: begin
        op        = OP_DIV_MIN;
        state_nxt = S_WMIN;
      end
      S_WMIN: begin
        if (!status.div_busy) begin
          op        = OP_SAVE_MIN;
          state_nxt = S_DMAX;
        end
      end
      S_DMAX: begin
        op        = OP_DIV_MAX;
        state_nxt = S_WMAX;
      end
      S_WMAX: begin
        if (!status.div_busy) begin
          op        = OP_SAVE_MAX;
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        op        = OP_FIRST;
        state_nxt = S_DFIRST;
      end
      S_DFIRST: begin
        op        = OP_DIV_FIRST;
        state_nxt = S_WFIRST;
      end
      S_WFIRST: begin
        if (!status.div_busy) begin
          op        = OP_SAVE_FIRST;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          op            = OP_EMIT;
          out_valid_nxt = 1'b1;
          if (status.emit_last) state_nxt = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (slot_free) begin
          op            = OP_EMPTY;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

// File: rtl/ruler_tick_generator_core.sv
// Top level of the ruler tick generator: controller, datapath and port wiring.
//
//  channel | direction | handshake              | beat carries
//  --------+-----------+------------------------+----------------------------------------
//  in_     | input     | in_valid / in_ready    | in_item_t: scale and visible range
//  out_    | output    | out_valid / out_ready  | out_item_t: one tick (or empty marker)
//  cfg_    | input     | cfg_we, no wait        | cfg_index selects register, cfg_data
//
// Before its first tick beat is valid, a request goes through load, scale and round,
// S = 1..28 search steps (one candidate per cycle), the major step, two divisions on
// the shared bit-serial divider, forming the first tick, a third division for its
// major residue, then loading the output register. Ticks then leave at one beat per
// cycle while out_ready is high, up to MAX_TICKS; an empty range skips the divisions
// and goes from the major step straight to its marker beat. Synchronous active-low reset
// returns the controller to idle and loads the register reset values; no clearing pass.
// A stalled out_ready holds the current beat in the output register and pauses
// tick stepping; in_ready is high only while the controller is idle, which it
// reaches as soon as the last beat sits in the output register.
module ruler_tick_generator_core #(
  parameter int unsigned MAX_TICKS = 64,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rtg_pkg::in_item_t              in_data,
  // tick channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output rtg_pkg::out_item_t             out_data,
  // register writes
  input  logic                           cfg_we,
  input  logic [rtg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rtg_pkg::*;

  // command from controller to datapath, status back
  dp_op_t     op;
  dp_status_t status;

  // sequence the request: load, search, divide, then step ticks out
  rtg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .op        (op)
  );

  // hold config, compute steps and range bounds, drive the output register
  rtg_dpath #(
    .MAX_TICKS (MAX_TICKS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .op        (op),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// File: bench/ruler_tick_generator_core_tb.sv
// Self-checking testbench for the ruler tick generator core.
module ruler_tick_generator_core_tb;
  import rtg_pkg::*;

  localparam int TICK_LIMIT = 64;
  localparam int FRAC_BITS = 8;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam longint VIEW_TOP = 64'sd2147483647;
  localparam longint VIEW_BOTTOM = -64'sd2147483648;

  // Predicts the tick beats of each view request from its own copy of the registers
  // and checks every beat the block hands out against the oldest prediction.
  class tick_ledger;
    logic [MPD_W-1:0] min_pixel = RST_MIN_PIXEL;
    logic [CFG_DATA_W-1:0] pref_step = RST_PREF_STEP;
    logic [SUB_W-1:0] subdiv = RST_SUBDIV;
    out_item_t expected_ticks[$];
    int unsigned requests, empties, cut_off, ticks_seen, mismatches;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MIN_PIXEL: min_pixel = val[MPD_W-1:0];
        CFG_PREF_STEP: pref_step = val;
        CFG_SUBDIV: subdiv = val[SUB_W-1:0];
        default: ;
      endcase
    endfunction

    // Smallest 1-2-5 step that keeps ticks apart on screen and honors the
    // preferred subdivision; saturates at the step cap.
    function longint unsigned minor_for(logic signed [IN_W-1:0] rpp);
      longint rpp_l;
      longint unsigned mag, pix, sub, base, n;
      rpp_l = rpp;
      mag = (rpp_l < 0) ? -rpp_l : rpp_l;
      pix = mag * ((min_pixel == 0) ? 64'd1 : 64'(min_pixel));
      sub = (subdiv == 0) ? 64'd1 : 64'(subdiv);
      base = 1;
      for (int k = 0; k <= 9; k++) begin
        for (int i = 0; i < 3; i++) begin
          n = base * ((i == 0) ? 1 : (i == 1) ? 2 : 5);
          if (n <= STEP_CAP && (n << 16) >= pix && (n << FRAC_BITS) * sub >= pref_step)
            return n;
        end
        base = base * 10;
      end
      return STEP_CAP;
    endfunction

    function void note_request(in_item_t r);
      longint unsigned minor, major;
      longint vmin, vmax, st, d, first, last, count, v, av;
      int emit;
      out_item_t t;
      minor = minor_for(r.real_per_pixel);
      major = pref_step >> FRAC_BITS;
      if (major > STEP_CAP) major = STEP_CAP;
      if (major < minor) major = minor;
      vmin = r.visible_min;
      vmax = r.visible_max;
      requests++;
      t = '0;
      t.minor_step = minor[STEP_W-1:0];
      t.major_step = major[STEP_W-1:0];
      // An empty range yields a single marker beat that still carries the steps.
      if (vmin >= vmax) begin
        t.is_empty = 1'b1;
        t.is_last = 1'b1;
        expected_ticks.insert(expected_ticks.size(), t);
        empties++;
        return;
      end
      st = minor;
      d = st * (64'sd1 <<< FRAC_BITS);
      // Round the lower bound down and the upper bound up to whole minor steps.
      first = vmin / d;
      if (vmin % d != 0 && vmin < 0) first--;
      first = first * st;
      last = vmax / d;
      if (vmax % d != 0 && vmax > 0) last++;
      last = last * st;
      count = (last - first) / st + 1;
      emit = (count > TICK_LIMIT) ? TICK_LIMIT : int'(count);
      if (count > TICK_LIMIT) cut_off++;
      v = first;
      for (int i = 0; i < emit; i++) begin
        av = (v < 0) ? -v : v;
        t.tick_value = v[TICK_W-1:0];
        t.is_major = (av % longint'(major)) == 0;
        t.is_last = (i == emit - 1);
        t.truncated = t.is_last && (count > TICK_LIMIT);
        expected_ticks.insert(expected_ticks.size(), t);
        v += st;
      end
    endfunction

    function void check_tick(out_item_t got);
      out_item_t exp;
      string diffs;
      ticks_seen++;
      if (expected_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tick beat with nothing expected: value %0d last %0b",
                   got.tick_value, got.is_last);
        return;
      end
      exp = expected_ticks.pop_front();
      diffs = "";
      if (got.tick_value !== exp.tick_value) diffs = {diffs, " tick_value"};
      if (got.is_major !== exp.is_major) diffs = {diffs, " is_major"};
      if (got.minor_step !== exp.minor_step) diffs = {diffs, " minor_step"};
      if (got.major_step !== exp.major_step) diffs = {diffs, " major_step"};
      if (got.is_empty !== exp.is_empty) diffs = {diffs, " is_empty"};
      if (got.truncated !== exp.truncated) diffs = {diffs, " truncated"};
      if (got.is_last !== exp.is_last) diffs = {diffs, " is_last"};
      if (diffs != "") begin
        mismatches++;
        if (mismatches <= 10)
          $display("tick mismatch in%s: expected %0d maj %0b steps %0d/%0d e%0b t%0b l%0b, %s",
                   diffs, exp.tick_value, exp.is_major, exp.minor_step, exp.major_step,
                   exp.is_empty, exp.truncated, exp.is_last,
                   $sformatf("got %0d maj %0b steps %0d/%0d e%0b t%0b l%0b",
                             got.tick_value, got.is_major, got.minor_step, got.major_step,
                             got.is_empty, got.truncated, got.is_last));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tick_ledger ledger = new;
  bit steady;             // no idling on either side while set
  int unsigned settings;
  int unsigned cycle_count;

  ruler_tick_generator_core #(
    .MAX_TICKS(TICK_LIMIT),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Stall the tick channel about 17 percent of the time, except in the steady stretch.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 17);
  end

  // Sample both handshakes at the rising edge; check the tick beat before noting a
  // new request so a stray beat never matches a fresh prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) ledger.check_tick(out_data);
      if (in_valid && in_ready) ledger.note_request(in_data);
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d ticks still expected",
               cycle_count, ledger.expected_ticks.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one view request and hold it until the block takes the beat. Entered and
  // left at a falling edge.
  task automatic send_request(input logic signed [IN_W-1:0] rpp,
                              input logic signed [IN_W-1:0] lo,
                              input logic signed [IN_W-1:0] hi);
    while (!steady && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{real_per_pixel: rpp, visible_min: lo, visible_max: hi};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drain all outstanding ticks, let the block settle, then write all three registers
  // back to back and drop the write enable once.
  task automatic load_config(input logic [CFG_DATA_W-1:0] mpd,
                             input logic [CFG_DATA_W-1:0] pref,
                             input logic [CFG_DATA_W-1:0] sub);
    logic [CFG_IDX_W-1:0] which[3];
    logic [CFG_DATA_W-1:0] vals[3];
    which = '{CFG_MIN_PIXEL, CFG_PREF_STEP, CFG_SUBDIV};
    vals = '{mpd, pref, sub};
    in_valid <= 1'b0;
    while (ledger.expected_ticks.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    @(negedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= which[i];
      cfg_data <= vals[i];
      ledger.write_reg(which[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    in_item_t req;
    longint vlo, vhi, d;
    longint unsigned minor;
    logic [CFG_DATA_W-1:0] mpd, pref, sub;
    int shape;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MIN_PIXEL;
    cfg_data = '0;
    steady = 1'b0;
    settings = 1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: minor step 10, major step 100 with a quiet scale.
    send_request(0, 0, 161280);                            // exactly the tick limit
    send_request(0, 0, 161281);                            // one tick over: cut off
    send_request(32'h80000000, 32'h80000000, 32'h7FFFFFFF);
    send_request(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_request(0, 32'h80000000, 32'h7FFFFFFF);           // negative ticks, cut off
    send_request(0, 1000, 1000);                           // empty: equal bounds
    send_request(0, 32'h7FFFFFFF, 32'h80000000);           // empty: reversed bounds
    send_request(-32'sd6553600, -32'sd5000, -32'sd100);    // scale forces a larger step
    send_request(-32'sd1, -32'sd1, 0);
    send_request(0, 0, 1);
    send_request(32'hFFFF0000, -32'sd17920, 32'sd7680);

    // All registers at zero: distance and subdivisions fall back to one, major step to the minor step.
    load_config(0, 0, 0);
    send_request(0, -32'sd2560, 32'sd2560);
    send_request(32'h00010000, 5, 300);
    send_request(32'h80000000, -32'sd100000, 32'sd100000);
    send_request(0, 0, 0);

    // All registers at their maximum.
    load_config(32'd4095, 32'hFFFFFFFF, 32'd255);
    send_request(32'h80000000, 32'h80000000, 32'h7FFFFFFF);
    send_request(0, 32'h80000000, 32'h7FFFFFFF);
    send_request(32'h7FFFFFFF, 0, 1);
    send_request(0, -32'sd5, -32'sd5);

    // Random phases, each with its own register setting. Most requests get a range sized in
    // whole minor steps, from none to a little past the tick limit; the rest are empty or noise.
    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(3))
        0: mpd = 0;
        1: mpd = 4095;
        2: mpd = $urandom_range(1, 64);
        default: mpd = $urandom_range(0, 4095);
      endcase
      mpd = mpd | ($urandom & 32'hFFFFF000);              // bits above the field are dropped
      case ($urandom_range(3))
        0: pref = 0;
        1: pref = 32'hFFFFFFFF;
        2: pref = $urandom_range(1, 2000) << FRAC_BITS;
        default: pref = $urandom;
      endcase
      case ($urandom_range(3))
        0: sub = 0;
        1: sub = 255;
        2: sub = $urandom_range(1, 20);
        default: sub = $urandom_range(0, 255);
      endcase
      sub = sub | ($urandom & 32'hFFFFFF00);
      load_config(mpd, pref, sub);
      steady = (p == 2);

      for (int n = 0; n < 66; n++) begin
        case ($urandom_range(3))
          0: req.real_per_pixel = $urandom;
          1: req.real_per_pixel = 0;
          default: begin
            req.real_per_pixel = $urandom_range(0, 32'h100000);
            if ($urandom_range(1)) req.real_per_pixel = -req.real_per_pixel;
          end
        endcase
        minor = ledger.minor_for(req.real_per_pixel);
        d = longint'(minor) << FRAC_BITS;
        if ($urandom_range(1))
          vlo = $signed($urandom);
        else
          vlo = longint'($urandom_range(0, 40000)) - 20000;
        shape = $urandom_range(9);
        if (shape == 0) begin
          vlo = $signed($urandom);
          vhi = $signed($urandom);
        end else if (shape == 1) begin
          vhi = vlo - longint'($urandom_range(0, 1000));
        end else begin
          vhi = vlo + d * longint'($urandom_range(0, 70)) + longint'($urandom_range(0, 600)) - 300;
        end
        if (vhi > VIEW_TOP) vhi = VIEW_TOP;
        if (vhi < VIEW_BOTTOM) vhi = VIEW_BOTTOM;
        send_request(req.real_per_pixel, vlo[IN_W-1:0], vhi[IN_W-1:0]);
      end
      steady = 1'b0;
    end

    // Drop valid, collect the remaining ticks and watch for stray beats.
    in_valid <= 1'b0;
    while (ledger.expected_ticks.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d view requests (%0d empty, %0d cut off) over %0d register settings",
             ledger.requests, ledger.empties, ledger.cut_off, settings);
    $display("checked %0d tick beats, %0d mismatching, %0d never arrived",
             ledger.ticks_seen, ledger.mismatches, ledger.expected_ticks.size());
    if (ledger.mismatches == 0 && ledger.expected_ticks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
